FILE: rtl/core/ocp_pkg.sv
// Shared types and constants for the order crossover block.
`timescale 1ns / 1ps
`default_nettype none

package ocp_pkg;

    localparam int GENE_BITS   = 10;
    localparam int POS_BITS    = 4;
    localparam int CUT_BITS    = 4;
    localparam int TEAM_BITS   = 5;
    localparam int OFFSET_BITS = 4;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    // register indexes (paddr[2])
    localparam logic REG_TEAM_SIZE  = 1'b0;
    localparam logic REG_CUT_OFFSET = 1'b1;

    localparam logic [TEAM_BITS-1:0]   TEAM_SIZE_RST  = 5'd4;
    localparam logic [OFFSET_BITS-1:0] CUT_OFFSET_RST = 4'd3;

    typedef struct packed {
        logic [GENE_BITS-1:0] gene_a;
        logic [GENE_BITS-1:0] gene_b;
        logic [CUT_BITS-1:0]  cut_point;
        logic                 load_last;
    } t_in_word;

    typedef struct packed {
        logic [GENE_BITS-1:0] child_gene;
        logic [POS_BITS-1:0]  child_position;
        logic                 child_last;
    } t_out_word;

    typedef struct packed {
        logic [TEAM_BITS-1:0]   team_size;
        logic [OFFSET_BITS-1:0] cut_offset;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/core/order_crossover_permutation.sv
// Top level of the order-1 (OX1) permutation crossover block.
`timescale 1ns / 1ps
`default_nettype none

// Order-1 crossover of two parent chromosomes. Load words arrive one gene
// pair per cycle in position order and are taken every cycle while loading;
// the word flagged load_last also carries the cut point and starts the
// crossover. The input stalls until the whole child has been handed to the
// output register. Crossover steps: the second end is reduced mod team size
// (at most 8 subtracts), then the ends are ordered; then for each parent B
// gene read (at most team_size of them) one shared comparator walks the
// parent A segment one gene per cycle against the B gene; emission of each
// child gene is a registered store read, then an output load, which waits
// while the output stalls. The output register lets the next load start
// while the last child word is still waiting. Child places left unfilled
// (parent B with repeated genes) come out as gene 0. Registers: team_size
// at paddr 0 (reset 4, used clamped to 2..MAX_GENES), cut_offset at paddr 4
// (reset 3).
module order_crossover_permutation #(
    parameter int MAX_GENES = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // load channel
    input  wire logic                            i_in_valid,
    input  wire ocp_pkg::t_in_word               i_in_word,
    output      logic                            o_in_stall,
    // child gene channel
    output      logic                            o_out_valid,
    output      ocp_pkg::t_out_word              o_out_word,
    input  wire logic                            i_out_stall,
    // config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ocp_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [ocp_pkg::PDATA_BITS-1:0]  pwdata,
    output      logic [ocp_pkg::PDATA_BITS-1:0]  prdata,
    output      logic                            pready
);

    ocp_pkg::t_cfg cfg;

    ocp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer, gene stores and output register
    ocp_core #(
        .MAX_GENES (MAX_GENES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ocp_cfg_regs.sv
// APB-style configuration registers: team size and cut offset.
`timescale 1ns / 1ps
`default_nettype none

module ocp_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ocp_pkg::PADDR_BITS-1:0]      paddr,
    input  wire logic [ocp_pkg::PDATA_BITS-1:0]      pwdata,
    output      logic [ocp_pkg::PDATA_BITS-1:0]      prdata,
    output      logic                                pready,
    output      ocp_pkg::t_cfg                       o_cfg
);

    logic [ocp_pkg::TEAM_BITS-1:0]   r_team_size;
    logic [ocp_pkg::OFFSET_BITS-1:0] r_cut_offset;
    logic                            reg_sel;
    logic                            wr_en;

    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_team_size  <= ocp_pkg::TEAM_SIZE_RST;
            r_cut_offset <= ocp_pkg::CUT_OFFSET_RST;
        end else if (wr_en) begin
            case (reg_sel)
                ocp_pkg::REG_TEAM_SIZE:  r_team_size  <= pwdata[ocp_pkg::TEAM_BITS-1:0];
                ocp_pkg::REG_CUT_OFFSET: r_cut_offset <= pwdata[ocp_pkg::OFFSET_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ocp_pkg::REG_TEAM_SIZE:  prdata = ocp_pkg::PDATA_BITS'(r_team_size);
            ocp_pkg::REG_CUT_OFFSET: prdata = ocp_pkg::PDATA_BITS'(r_cut_offset);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.team_size  = r_team_size;
    assign o_cfg.cut_offset = r_cut_offset;

endmodule

`default_nettype wire

FILE: rtl/core/ocp_core.sv
// Gene stores, crossover sequencer with shared compare unit, output register.
`timescale 1ns / 1ps
`default_nettype none

module ocp_core #(
    parameter int MAX_GENES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ocp_pkg::t_cfg       i_cfg,
    input  wire logic                i_in_valid,
    input  wire ocp_pkg::t_in_word   i_in_word,
    output      logic                o_in_stall,
    output      logic                o_out_valid,
    output      ocp_pkg::t_out_word  o_out_word,
    input  wire logic                i_out_stall
);

    localparam int IW = $clog2(MAX_GENES);
    localparam int CW = $clog2(MAX_GENES + 1);
    localparam int SW = ((IW > ocp_pkg::CUT_BITS) ? IW : ocp_pkg::CUT_BITS) + 1;
    localparam int GB = ocp_pkg::GENE_BITS;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_MOD   = 6'b000010,
        ST_BREAD = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_ERD   = 6'b010000,
        ST_EOUT  = 6'b100000
    } t_state;

    // gene stores
    logic [GB-1:0] r_mem_a [MAX_GENES];
    logic [GB-1:0] r_mem_b [MAX_GENES];
    logic [GB-1:0] r_mem_c [MAX_GENES];
    logic [GB-1:0] r_rd_a, r_rd_b, r_rd_c;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_load_pos, n_load_pos;
    logic [CW-1:0]      r_n, n_n;
    logic [IW-1:0]      r_lo, n_lo;
    logic [IW-1:0]      r_hi, n_hi;
    logic [SW-1:0]      r_sum, n_sum;
    logic [IW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_j, n_j;
    logic [IW-1:0]      r_k, n_k;
    logic [IW-1:0]      r_cur, n_cur;
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_seen, n_seen;
    logic [IW-1:0]      r_p, n_p;
    logic               r_out_valid, n_out_valid;
    ocp_pkg::t_out_word r_out_word, n_out_word;

    logic          in_accept;
    logic          load_we;
    logic          child_we;
    logic [IW-1:0] a_raddr;
    logic [31:0]   ts_ext;
    logic [31:0]   cut_ext;
    logic [CW-1:0] team_n;
    logic [IW-1:0] cut_c;
    logic [IW-1:0] mod_h;
    logic [IW-1:0] hi_v;
    logic [IW-1:0] cur_v;
    logic [CW-1:0] fill_dist;
    logic          in_seg;
    logic          filled;
    logic          pos_last;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_LOAD);

    // active team size from config and clamped cut from the load word
    assign ts_ext  = 32'(i_cfg.team_size);
    assign cut_ext = 32'(i_in_word.cut_point);
    assign team_n  = (ts_ext < 32'd2) ? CW'(2) :
                     (ts_ext > 32'(MAX_GENES)) ? CW'(MAX_GENES) : CW'(ts_ext);
    assign cut_c   = (cut_ext >= 32'(team_n)) ? IW'(team_n - CW'(1)) : IW'(cut_ext);

    assign mod_h = IW'(r_sum);

    // emit-side decode: segment, fill region (distance from hi, wrapping)
    assign in_seg    = (r_p >= r_lo) && (r_p < r_hi);
    assign fill_dist = (r_p >= r_hi) ? (CW'(r_p) - CW'(r_hi))
                                     : (CW'(r_p) + r_n - CW'(r_hi));
    assign filled    = fill_dist < r_fill;
    assign pos_last  = (CW'(r_p) == (r_n - CW'(1)));

    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_j         = r_j;
        n_k         = r_k;
        n_cur       = r_cur;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_p         = r_p;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        load_we     = 1'b0;
        child_we    = 1'b0;
        a_raddr     = r_lo;
        hi_v        = r_hi;
        cur_v       = r_cur;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_accept) begin
                    load_we = (r_load_pos < CW'(MAX_GENES));
                    if (i_in_word.load_last) begin
                        n_load_pos = '0;
                        n_n        = team_n;
                        n_lo       = cut_c;
                        n_sum      = SW'(cut_c) + SW'(i_cfg.cut_offset);
                        n_state    = ST_MOD;
                    end else if (load_we) begin
                        n_load_pos = r_load_pos + CW'(1);
                    end
                end
            end
            ST_MOD: begin
                // second end mod team size by repeated subtract
                if (r_sum >= SW'(r_n)) begin
                    n_sum = r_sum - SW'(r_n);
                end else begin
                    if (r_lo > mod_h) begin
                        n_lo = mod_h;
                        hi_v = r_lo;
                    end else begin
                        hi_v = mod_h;
                    end
                    n_hi    = hi_v;
                    n_idx   = hi_v;
                    n_cur   = hi_v;
                    n_j     = '0;
                    n_fill  = '0;
                    n_state = ST_BREAD;
                end
            end
            ST_BREAD: begin
                n_k     = r_lo;
                n_seen  = 1'b0;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_k != r_hi) begin
                    a_raddr = r_k + IW'(1);
                    n_k     = r_k + IW'(1);
                    n_seen  = r_seen | (r_rd_a == r_rd_b);
                end else begin
                    if (!r_seen) begin
                        child_we = 1'b1;
                        cur_v    = (CW'(r_cur) == (r_n - CW'(1))) ? '0 : (r_cur + IW'(1));
                        n_fill   = r_fill + CW'(1);
                    end
                    n_cur = cur_v;
                    if ((cur_v == r_lo) || (r_j == (r_n - CW'(1)))) begin
                        n_p     = '0;
                        n_state = ST_ERD;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_idx   = (CW'(r_idx) == (r_n - CW'(1))) ? '0 : (r_idx + IW'(1));
                        n_state = ST_BREAD;
                    end
                end
            end
            ST_ERD: begin
                a_raddr = r_p;
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                a_raddr = r_p;
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word.child_gene     = in_seg ? r_rd_a : (filled ? r_rd_c : '0);
                    n_out_word.child_position = ocp_pkg::POS_BITS'(r_p);
                    n_out_word.child_last     = pos_last;
                    if (pos_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_p     = r_p + IW'(1);
                        n_state = ST_ERD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_load_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_pos  <= n_load_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_sum      <= n_sum;
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_k        <= n_k;
        r_cur      <= n_cur;
        r_fill     <= n_fill;
        r_seen     <= n_seen;
        r_p        <= n_p;
        r_out_word <= n_out_word;
    end

    // stores: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem_a[r_load_pos[IW-1:0]] <= i_in_word.gene_a;
            r_mem_b[r_load_pos[IW-1:0]] <= i_in_word.gene_b;
        end
        if (child_we) begin
            r_mem_c[r_cur] <= r_rd_b;
        end
        r_rd_a <= r_mem_a[a_raddr];
        r_rd_b <= r_mem_b[r_idx];
        r_rd_c <= r_mem_c[r_p];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: test/tb_order_crossover_permutation.sv
// Self-checking testbench for the order-1 permutation crossover block.
`timescale 1ns / 1ps

// Parent pairs go in one word per gene position. A local model of the
// crossover turns each word that closes a load into the child genes it
// should produce. Every child word taken from the block is checked against
// the oldest one still due. Both channels idle and stall at random. The
// registers are rewritten between load phases, and are written only once
// the block has gone quiet.
module tb_order_crossover_permutation;

    localparam int MAX_GENES     = 16;
    localparam int GB            = ocp_pkg::GENE_BITS;
    localparam int LOAD_MAX      = 20;      // bound on load length, past the store
    localparam int IDLE_PCT      = 12;
    localparam int SETTLE_CYCLES = 40;      // block drains after last child word
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 300;
    localparam int PHASES        = 10;

    typedef enum int {
        PARENTS_PERM,                       // A and B permute the same gene set
        PARENTS_DUP_B,                      // B repeats A genes, fill ends early
        PARENTS_NOISE                       // unrelated random genes
    } t_parent_mix;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    ocp_pkg::t_in_word              in_word   = '0;
    logic                           in_stall;
    logic                           out_valid;
    ocp_pkg::t_out_word             out_word;
    logic                           out_stall = 1'b0;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [ocp_pkg::PADDR_BITS-1:0] paddr     = '0;
    logic [ocp_pkg::PDATA_BITS-1:0] pwdata    = '0;
    logic [ocp_pkg::PDATA_BITS-1:0] prdata;
    logic                           pready;

    order_crossover_permutation #(
        .MAX_GENES(MAX_GENES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_word (out_word),
        .i_out_stall(out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // Model state: our copy of the parent stores and the registers.
    logic [GB-1:0]                   store_a [MAX_GENES];
    logic [GB-1:0]                   store_b [MAX_GENES];
    logic [MAX_GENES-1:0]            loaded_mask = '0;  // places written since reset
    int                              load_pos    = 0;
    logic [ocp_pkg::TEAM_BITS-1:0]   cfg_team    = ocp_pkg::TEAM_SIZE_RST;
    logic [ocp_pkg::OFFSET_BITS-1:0] cfg_offset  = ocp_pkg::CUT_OFFSET_RST;

    ocp_pkg::t_out_word              child_genes_due [$];
    logic [GB-1:0]                   gene_a_buf [LOAD_MAX];
    logic [GB-1:0]                   gene_b_buf [LOAD_MAX];

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  cycle_count    = 0;
    bit  quiet          = 1'b0;            // no idling on either side

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // team_size acts clamped to 2..MAX_GENES
    function automatic int genes_in_use();
        int n;
        n = int'(cfg_team);
        if (n < 2) n = 2;
        if (n > MAX_GENES) n = MAX_GENES;
        return n;
    endfunction

    // OX1: A's segment [lo,hi) stays, the rest is filled from B starting at hi,
    // skipping genes that sit in the segment. Unfilled places stay 0.
    function automatic void cross_parents(input logic [ocp_pkg::CUT_BITS-1:0] cut_pt);
        logic [GB-1:0]      child [MAX_GENES];
        logic [GB-1:0]      g;
        ocp_pkg::t_out_word w;
        int                 n, cut, lo, hi, tmp, cur, k, j;
        bit                 seen;
        n   = genes_in_use();
        cut = int'(cut_pt);
        if (cut >= n) cut = n - 1;
        lo = cut;
        hi = (cut + int'(cfg_offset)) % n;
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        for (k = 0; k < MAX_GENES; k++) child[k] = '0;
        for (k = lo; k < hi; k++) child[k] = store_a[k];
        cur = hi;
        for (j = 0; j < n; j++) begin
            g    = store_b[(hi + j) % n];
            seen = 1'b0;
            for (k = lo; k < hi; k++)
                if (child[k] == g) seen = 1'b1;
            if (!seen) begin
                child[cur] = g;
                cur = (cur + 1) % n;
            end
            if (cur == lo) break;
        end
        for (k = 0; k < n; k++) begin
            w.child_gene     = child[k];
            w.child_position = k[ocp_pkg::POS_BITS-1:0];
            w.child_last     = (k == n - 1);
            child_genes_due  = {child_genes_due, w};
        end
    endfunction

    // Pairs past the store are dropped; a closing word still starts a crossover.
    function automatic void absorb_word(input ocp_pkg::t_in_word w);
        if (load_pos < MAX_GENES) begin
            store_a[load_pos]     = w.gene_a;
            store_b[load_pos]     = w.gene_b;
            loaded_mask[load_pos] = 1'b1;
            load_pos++;
        end
        if (w.load_last) begin
            cross_parents(w.cut_point);
            load_pos = 0;
        end
    endfunction

    task automatic send_word(input ocp_pkg::t_in_word w);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        absorb_word(w);
        words_sent++;
    endtask

    task automatic send_pair(input int ga, input int gb, input int cut, input bit last);
        ocp_pkg::t_in_word w;
        w.gene_a    = ga[GB-1:0];
        w.gene_b    = gb[GB-1:0];
        w.cut_point = cut[ocp_pkg::CUT_BITS-1:0];
        w.load_last = last;
        send_word(w);
    endtask

    // Lower valid and hold the load side until every child word is out.
    task automatic drain_children();
        in_valid <= 1'b0;
        @(posedge clk);
        while (child_genes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ocp_pkg::PADDR_BITS-1:0] addr,
                             input logic [ocp_pkg::PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [ocp_pkg::PADDR_BITS-1:0] addr,
                            output logic [ocp_pkg::PDATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_registers();
        logic [ocp_pkg::PDATA_BITS-1:0] rd;
        apb_read({ocp_pkg::REG_TEAM_SIZE, 2'b00}, rd);
        if (rd[ocp_pkg::TEAM_BITS-1:0] != cfg_team)
            flag_mismatch("team_size read", int'(rd[ocp_pkg::TEAM_BITS-1:0]),
                          int'(cfg_team));
        apb_read({ocp_pkg::REG_CUT_OFFSET, 2'b00}, rd);
        if (rd[ocp_pkg::OFFSET_BITS-1:0] != cfg_offset)
            flag_mismatch("cut_offset read", int'(rd[ocp_pkg::OFFSET_BITS-1:0]),
                          int'(cfg_offset));
    endtask

    // Drains the block first, so the registers are written only while it is idle.
    task automatic set_config(input int team, input int offset);
        drain_children();
        apb_write({ocp_pkg::REG_TEAM_SIZE, 2'b00}, team);
        cfg_team = team[ocp_pkg::TEAM_BITS-1:0];
        apb_write({ocp_pkg::REG_CUT_OFFSET, 2'b00}, offset);
        cfg_offset = offset[ocp_pkg::OFFSET_BITS-1:0];
        check_registers();
    endtask

    function automatic void fill_parents(input int n, input t_parent_mix mix);
        logic [GB-1:0] vals [MAX_GENES];
        logic [GB-1:0] tmp;
        bit   [1023:0] used;
        int            k, j, v;
        used = '0;
        for (k = 0; k < n; k++) begin
            do v = int'($urandom_range(1023)); while (used[v]);
            used[v] = 1'b1;
            vals[k] = v[GB-1:0];
            gene_a_buf[k] = vals[k];
        end
        for (k = n - 1; k > 0; k--) begin
            j       = int'($urandom_range(k));
            tmp     = vals[k];
            vals[k] = vals[j];
            vals[j] = tmp;
        end
        for (k = 0; k < n; k++) gene_b_buf[k] = vals[k];
        for (k = n; k < LOAD_MAX; k++) begin
            gene_a_buf[k] = GB'($urandom_range(1023));
            gene_b_buf[k] = GB'($urandom_range(1023));
        end
        if (mix == PARENTS_DUP_B)
            for (k = 0; k < n; k++) gene_b_buf[k] = gene_a_buf[$urandom_range(n - 1)];
        if (mix == PARENTS_NOISE)
            for (k = 0; k < LOAD_MAX; k++) begin
                gene_a_buf[k] = GB'($urandom_range(1023));
                gene_b_buf[k] = GB'($urandom_range(1023));
            end
    endfunction

    task automatic send_chromosome(input int len, input int cut);
        int k;
        for (k = 0; k < len; k++)
            send_pair(int'(gene_a_buf[k]), int'(gene_b_buf[k]),
                      (k == len - 1) ? cut : int'($urandom_range(15)), k == len - 1);
    endtask

    // Child checker and receiver stall. The stall seen at this edge is the
    // one the block saw, so it decides whether a word moved.
    always @(posedge clk) begin
        ocp_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (child_genes_due.size() == 0) begin
                flag_mismatch("child word with none due", int'(out_word), 0);
            end else begin
                want = child_genes_due.pop_front();
                if (out_word.child_gene != want.child_gene)
                    flag_mismatch("child_gene", int'(out_word.child_gene),
                                  int'(want.child_gene));
                if (out_word.child_position != want.child_position)
                    flag_mismatch("child_position", int'(out_word.child_position),
                                  int'(want.child_position));
                if (out_word.child_last != want.child_last)
                    flag_mismatch("child_last", int'(out_word.child_last),
                                  int'(want.child_last));
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_reset_registers();
        check_registers();
    endtask

    task automatic test_directed_cases();
        int k;
        // defaults, gene extremes, cut past team size clamps to 3
        send_pair(0,    1023, 0,  1'b0);
        send_pair(1023, 0,    15, 1'b0);
        send_pair(3,    1023, 5,  1'b0);
        send_pair(9,    3,    15, 1'b1);
        // team_size below range acts as 2; zero offset gives an empty segment
        set_config(1, 0);
        send_pair(11, 22, 0, 1'b0);
        send_pair(22, 11, 0, 1'b1);
        // B only repeats the segment gene: second place stays 0
        set_config(2, 1);
        send_pair(7, 7, 0, 1'b0);
        send_pair(8, 7, 0, 1'b1);
        // short load: place 1 keeps the gene of the previous load
        send_pair(8, 7, 1, 1'b1);
        // team_size above range acts as 16; the 17th pair falls off the store
        set_config(31, 15);
        fill_parents(MAX_GENES, PARENTS_PERM);
        for (k = 0; k <= MAX_GENES; k++)
            send_pair(int'(gene_a_buf[k]), int'(gene_b_buf[k]),
                      (k == MAX_GENES) ? 15 : 0, k == MAX_GENES);
    endtask

    task automatic test_random_phases();
        int          teams   [PHASES] = '{2, 16, 0, 1, 17, 31, 5, 9, 12, 6};
        int          offsets [PHASES] = '{0, 15, 1, 15, 7, 3, 0, 2, 11, 4};
        int          p, n, len, min_len, cut, k, phase_start, pick;
        t_parent_mix mix;
        for (p = 0; p < PHASES; p++) begin
            if (p >= PHASES - 2) begin
                teams[p]   = int'($urandom_range(31));
                offsets[p] = int'($urandom_range(15));
            end
            set_config(teams[p], offsets[p]);
            quiet       = (p == 6);
            phase_start = words_sent;
            n           = genes_in_use();
            while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
                // a short load may only leave places that an earlier load filled
                min_len = 1;
                for (k = 0; k < n; k++)
                    if (!loaded_mask[k]) min_len = k + 1;
                pick = int'($urandom_range(99));
                if (pick < 10 && min_len < n) len = int'($urandom_range(n - 1, min_len));
                else if (pick < 20)           len = int'($urandom_range(LOAD_MAX - 1, n + 1));
                else                          len = n;
                pick = int'($urandom_range(99));
                mix  = (pick < 8)  ? PARENTS_NOISE :
                       (pick < 18) ? PARENTS_DUP_B : PARENTS_PERM;
                cut  = ($urandom_range(99) < 15) ? int'($urandom_range(15))
                                                 : int'($urandom_range(n - 1));
                fill_parents(n, mix);
                send_chromosome(len, cut);
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_registers();
        test_directed_cases();
        test_random_phases();
        drain_children();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
